>>> rtl/skvt_pkg.sv
`timescale 1ns / 1ps

package skvt_pkg;

   // payload widths
   localparam int MODE_W      = 2;
   localparam int KEY_W       = 32;
   localparam int VAL_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED_KEYS = 1'd1;

   localparam logic [CSR_DATA_W-1:0] MAX_ENTRIES_RESET = 7'd64;

   // request modes
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   // response codes
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [VAL_W-1:0] val_type;

endpackage

>>> rtl/skvt_req_if.sv
`timescale 1ns / 1ps

interface skvt_req_if;
   logic                         valid;
   logic                         ready;
   logic [skvt_pkg::MODE_W-1:0]  mode;
   skvt_pkg::key_type            key;
   skvt_pkg::val_type            entry_value;

   modport source (output valid, output mode, output key, output entry_value, input ready);
   modport sink   (input valid, input mode, input key, input entry_value, output ready);
endinterface

>>> rtl/skvt_rsp_if.sv
`timescale 1ns / 1ps

interface skvt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [skvt_pkg::STATUS_W-1:0]     status;
   skvt_pkg::val_type                 found_value;
   logic [skvt_pkg::COUNT_OUT_W-1:0]  count_after;

   modport source (output valid, output status, output found_value, output count_after,
                   input ready);
   modport sink   (input valid, input status, input found_value, input count_after,
                   output ready);
endinterface

>>> rtl/skvt_ram.sv
`timescale 1ns / 1ps

module skvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sorted_key_value_table_top.sv
`timescale 1ns / 1ps

// sorted key/value table, one request in flight at a time, entries scanned one per cycle
// lookup or remove scans up from entry 0 to the match, remove then moves the entries above it down
// a miss scans every stored entry; insert scans to the first key >= its own, shifts the tail up, writes the pair
// clear and refused insert skip the scan; next request accepted in the cycle after the response loads,
// the response load waits while the output register holds a beat not yet taken
// reset: entry count 0, max_entries 64, unsigned keys; entry memories are not cleared

module sorted_key_value_table_top #(
   parameter int CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   skvt_req_if.sink                          req_chan,
   skvt_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [skvt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [skvt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   // width that holds both the count and the 7-bit limit register
   localparam int LW = (CW > skvt_pkg::CSR_DATA_W) ? CW : skvt_pkg::CSR_DATA_W;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHUP,
      ST_PUT,
      ST_SHDN,
      ST_FIN
   } state_type;

   state_type                          state_ff;

   // configuration
   logic [skvt_pkg::CSR_DATA_W-1:0]    max_entries_ff;
   logic                               signed_keys_ff;

   // table control
   logic [CW-1:0]                      count_ff;
   logic [CW-1:0]                      ptr_ff;      // next address to read
   logic [CW-1:0]                      chk_ff;      // address of the entry on the read data
   logic                               chk_vld_ff;
   logic [CW-1:0]                      pos_ff;      // insert slot
   logic [CW-1:0]                      wr_addr_ff;  // destination of the pending move
   logic                               wr_vld_ff;

   // captured request beat
   logic [skvt_pkg::MODE_W-1:0]        op_ff;
   skvt_pkg::key_type                  key_ff;
   skvt_pkg::val_type                  val_ff;

   // finished result and output register
   logic [skvt_pkg::STATUS_W-1:0]      res_status_ff;
   skvt_pkg::val_type                  res_found_ff;
   logic                               rsp_valid_ff;
   logic [skvt_pkg::STATUS_W-1:0]      rsp_status_ff;
   skvt_pkg::val_type                  rsp_found_ff;
   logic [skvt_pkg::COUNT_OUT_W-1:0]   rsp_count_ff;

   // memory ports
   logic                               mem_we;
   logic [AW-1:0]                      mem_waddr;
   logic [AW-1:0]                      mem_raddr;
   skvt_pkg::key_type                  key_wdata;
   skvt_pkg::val_type                  val_wdata;
   skvt_pkg::key_type                  key_rdata;
   skvt_pkg::val_type                  val_rdata;

   logic                               req_beat;
   logic                               table_full;
   logic                               in_range;
   logic                               key_eq;
   logic                               key_ge;
   logic                               hit;
   logic [LW-1:0]                      count_wide;
   logic [CW-1:0]                      ptr_dec;

   skvt_ram #(.WIDTH(skvt_pkg::KEY_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (key_wdata),
      .rd_addr (mem_raddr),
      .rd_data (key_rdata)
   );

   skvt_ram #(.WIDTH(skvt_pkg::VAL_W), .DEPTH(CAPACITY)) u_val_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (val_wdata),
      .rd_addr (mem_raddr),
      .rd_data (val_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;

   assign count_wide = LW'(count_ff);
   // limit is the smaller of max_entries and the memory depth
   assign table_full = (count_wide >= LW'(max_entries_ff)) || (count_ff == CAP_COUNT);

   // compare the stored key on the read data against the request key
   assign in_range = chk_ff < count_ff;
   assign key_eq   = (key_rdata == key_ff);
   // two's complement order is unsigned order with the sign bit flipped
   assign key_ge   = {key_rdata[skvt_pkg::KEY_W-1] ^ signed_keys_ff,
                      key_rdata[skvt_pkg::KEY_W-2:0]} >=
                     {key_ff[skvt_pkg::KEY_W-1] ^ signed_keys_ff,
                      key_ff[skvt_pkg::KEY_W-2:0]};
   assign hit      = in_range && ((op_ff == skvt_pkg::MODE_INSERT) ? key_ge : key_eq);

   assign ptr_dec = ptr_ff - CW'(1);

   // read address: shift up reads the entry below its destination
   always_comb begin
      mem_raddr = ptr_ff[AW-1:0];
      if (state_ff == ST_SHUP) begin
         mem_raddr = ptr_dec[AW-1:0];
      end
   end

   // write port: new pair on put, else the pending move of last cycle's read
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff[AW-1:0];
      key_wdata = key_rdata;
      val_wdata = val_rdata;
      if (state_ff == ST_PUT) begin
         mem_we    = 1'b1;
         mem_waddr = pos_ff[AW-1:0];
         key_wdata = key_ff;
         val_wdata = val_ff;
      end else if ((state_ff == ST_SHUP || state_ff == ST_SHDN) && wr_vld_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         max_entries_ff <= skvt_pkg::MAX_ENTRIES_RESET;
         signed_keys_ff <= 1'b0;
         count_ff       <= '0;
         chk_vld_ff     <= 1'b0;
         wr_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // configuration writes
         if (csr_we) begin
            unique case (csr_index)
               skvt_pkg::CSR_MAX_ENTRIES: max_entries_ff <= csr_wdata;
               skvt_pkg::CSR_SIGNED_KEYS: signed_keys_ff <= csr_wdata[0];
               default: ;
            endcase
         end

         // output register drains on a response beat, in fin the reload takes its place
         if (rsp_valid_ff && rsp_chan.ready && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  op_ff        <= req_chan.mode;
                  key_ff       <= req_chan.key;
                  val_ff       <= req_chan.entry_value;
                  res_found_ff <= '0;
                  ptr_ff       <= '0;
                  chk_vld_ff   <= 1'b0;
                  if (req_chan.mode == skvt_pkg::MODE_CLEAR) begin
                     count_ff      <= '0;
                     res_status_ff <= skvt_pkg::STATUS_DONE;
                     state_ff      <= ST_FIN;
                  end else if (req_chan.mode == skvt_pkg::MODE_INSERT && table_full) begin
                     res_status_ff <= skvt_pkg::STATUS_FULL;
                     state_ff      <= ST_FIN;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end

            ST_SCAN: begin
               // one read issued and one entry checked per cycle
               chk_ff     <= ptr_ff;
               chk_vld_ff <= 1'b1;
               if (chk_vld_ff && (hit || !in_range)) begin
                  wr_vld_ff <= 1'b0;
                  if (op_ff == skvt_pkg::MODE_INSERT) begin
                     // slot found, move the tail up starting from the top
                     pos_ff   <= chk_ff;
                     ptr_ff   <= count_ff;
                     state_ff <= ST_SHUP;
                  end else if (!hit) begin
                     res_status_ff <= skvt_pkg::STATUS_MISS;
                     state_ff      <= ST_FIN;
                  end else if (op_ff == skvt_pkg::MODE_REMOVE) begin
                     ptr_ff   <= chk_ff + CW'(1);
                     state_ff <= ST_SHDN;
                  end else begin
                     res_status_ff <= skvt_pkg::STATUS_DONE;
                     res_found_ff  <= val_rdata;
                     state_ff      <= ST_FIN;
                  end
               end else begin
                  ptr_ff <= ptr_ff + CW'(1);
               end
            end

            ST_SHUP: begin
               if (ptr_ff > pos_ff) begin
                  wr_addr_ff <= ptr_ff;
                  wr_vld_ff  <= 1'b1;
                  ptr_ff     <= ptr_dec;
               end else begin
                  wr_vld_ff <= 1'b0;
                  state_ff  <= ST_PUT;
               end
            end

            ST_PUT: begin
               count_ff      <= count_ff + CW'(1);
               res_status_ff <= skvt_pkg::STATUS_DONE;
               state_ff      <= ST_FIN;
            end

            ST_SHDN: begin
               // close the gap, last move is written in the exit cycle
               if (ptr_ff < count_ff) begin
                  wr_addr_ff <= ptr_dec;
                  wr_vld_ff  <= 1'b1;
                  ptr_ff     <= ptr_ff + CW'(1);
               end else begin
                  wr_vld_ff     <= 1'b0;
                  count_ff      <= count_ff - CW'(1);
                  res_status_ff <= skvt_pkg::STATUS_DONE;
                  state_ff      <= ST_FIN;
               end
            end

            ST_FIN: begin
               // hand the result to the output register once it is free
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_found_ff  <= res_found_ff;
                  rsp_count_ff  <= count_wide[skvt_pkg::COUNT_OUT_W-1:0];
                  state_ff      <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_value = rsp_found_ff;
   assign rsp_chan.count_after = rsp_count_ff;

endmodule
